[hdl/tcpq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants for the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int unsigned DEF_CAPACITY  = 16;
    localparam int unsigned DEF_ID_BITS   = 16;
    localparam int unsigned PORT_ID_W     = 16;
    localparam int unsigned KEY_W         = 8;
    localparam logic [KEY_W-1:0] THRESHOLD_RESET = 8'd60;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_SERVE    = 2'd1,
        ACT_WITHDRAW = 2'd2,
        ACT_QUERY    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ORD_RD,
        S_SLOT_RD,
        S_CMP,
        S_ALLOC,
        S_ALLOC_W,
        S_SLOT_WR,
        S_INS_RD,
        S_INS_WR,
        S_REM,
        S_REM_WR,
        S_FINAL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[hdl/tcpq_order_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_order_ram
// Service order memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcpq_order_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [AW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [AW-1:0] o_rdata
);

    logic [AW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hdl/tcpq_slot_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_slot_ram
// Entry storage: id and key of each slot, registered read data.
// ----------------------------------------------------------------------------
module tcpq_slot_ram #(
    parameter int unsigned DEPTH   = 16,
    parameter int unsigned AW      = 4,
    parameter int unsigned ID_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [ID_BITS-1:0]         i_wid,
    input  wire logic [tcpq_pkg::KEY_W-1:0] i_wkey,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [ID_BITS-1:0]         o_rid,
    output logic      [tcpq_pkg::KEY_W-1:0] o_rkey
);
    import tcpq_pkg::*;

    logic [ID_BITS+KEY_W-1:0] r_mem [DEPTH];
    logic [ID_BITS+KEY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wid, i_wkey};
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rid  = r_rdata[ID_BITS+KEY_W-1:KEY_W];
    assign o_rkey = r_rdata[KEY_W-1:0];

endmodule
`default_nettype wire

[hdl/two_class_priority_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Bounded two-class FIFO: preferred entries are served before normal ones.
// ----------------------------------------------------------------------------
// One word in gives one word out. Entries live in a slot memory (id, key) and
// the service order in an order memory of slot numbers; both have registered
// read data and the controller walks them one access at a time. An id search
// reads each held entry in turn (order read, slot read, compare); an insert
// shift or a removal shift reads and then writes each moved position. A new
// word is taken only while idle; a finished result sits in the output
// register while the next word is taken.
module two_class_priority_queue #(
    parameter int unsigned CAPACITY = tcpq_pkg::DEF_CAPACITY,
    parameter int unsigned ID_BITS  = tcpq_pkg::DEF_ID_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [tcpq_pkg::KEY_W-1:0]           i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_action,
    input  wire logic [tcpq_pkg::PORT_ID_W-1:0]       i_person_id,
    input  wire logic [tcpq_pkg::KEY_W-1:0]           i_person_age,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [2:0]                                o_status,
    output logic [tcpq_pkg::PORT_ID_W-1:0]            o_served_id,
    output logic [tcpq_pkg::KEY_W-1:0]                o_found_age,
    output logic [$clog2(CAPACITY+1)-1:0]             o_entry_count
);
    import tcpq_pkg::*;

    localparam int unsigned SW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // control and state registers
    t_state          r_state, n_state;
    t_action         r_action, n_action;
    t_status         r_status, n_status;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [CW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_k, n_k;
    logic [SW-1:0]   r_slot, n_slot;
    logic [CW-1:0]   r_total, n_total;
    logic [CW-1:0]   r_pref, n_pref;
    logic [CW-1:0]   r_fill, n_fill;
    logic [PORT_ID_W-1:0] r_served, n_served;
    logic [KEY_W-1:0]     r_age, n_age;
    logic [KEY_W-1:0]     r_thresh;

    // output register
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [PORT_ID_W-1:0] r_out_served, n_out_served;
    logic [KEY_W-1:0]     r_out_age, n_out_age;
    logic [CW-1:0]        r_out_count, n_out_count;

    // memory ports
    logic          ord_we;
    logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic          slot_we;
    logic [SW-1:0] slot_raddr;
    logic [ID_BITS-1:0] slot_rid;
    logic [KEY_W-1:0]   slot_rkey;

    logic is_pref;

    tcpq_order_ram #(.DEPTH(CAPACITY), .AW(SW)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    tcpq_slot_ram #(.DEPTH(CAPACITY), .AW(SW), .ID_BITS(ID_BITS)) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_slot),
        .i_wid   (r_id),
        .i_wkey  (r_key),
        .i_raddr (slot_raddr),
        .o_rid   (slot_rid),
        .o_rkey  (slot_rkey)
    );

    assign is_pref     = (r_key >= r_thresh);
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_served_id   = r_out_served;
    assign o_found_age   = r_out_age;
    assign o_entry_count = r_out_count;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_pref      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_pref      <= n_pref;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_status     <= n_status;
        r_id         <= n_id;
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_k          <= n_k;
        r_slot       <= n_slot;
        r_served     <= n_served;
        r_age        <= n_age;
        r_out_status <= n_out_status;
        r_out_served <= n_out_served;
        r_out_age    <= n_out_age;
        r_out_count  <= n_out_count;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_status     = r_status;
        n_id         = r_id;
        n_key        = r_key;
        n_pos        = r_pos;
        n_k          = r_k;
        n_slot       = r_slot;
        n_total      = r_total;
        n_pref       = r_pref;
        n_fill       = r_fill;
        n_served     = r_served;
        n_age        = r_age;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_served = r_out_served;
        n_out_age    = r_out_age;
        n_out_count  = r_out_count;
        ord_we       = 1'b0;
        ord_waddr    = r_k[SW-1:0];
        ord_wdata    = ord_rdata;
        ord_raddr    = r_pos[SW-1:0];
        slot_we      = 1'b0;
        slot_raddr   = ord_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = t_action'(i_action);
                    n_id     = ID_BITS'(i_person_id);
                    n_key    = i_person_age;
                    n_pos    = '0;
                    n_status = ST_OK;
                    n_served = '0;
                    n_age    = '0;
                    if (r_total == '0) begin
                        unique case (t_action'(i_action))
                            ACT_INSERT: n_state = S_ALLOC;
                            ACT_SERVE: begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end
                            default: begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_DONE;
                            end
                        endcase
                    end else begin
                        n_state = S_ORD_RD;
                    end
                end
            end
            S_ORD_RD: begin
                ord_raddr = r_pos[SW-1:0];
                n_state   = S_SLOT_RD;
            end
            S_SLOT_RD: begin
                n_slot     = ord_rdata;
                slot_raddr = ord_rdata;
                n_state    = S_CMP;
            end
            S_CMP: begin
                if (r_action == ACT_SERVE) begin
                    n_served = PORT_ID_W'(slot_rid);
                    n_k      = r_pos;
                    n_state  = S_REM;
                end else if (slot_rid == r_id) begin
                    unique case (r_action)
                        ACT_INSERT: begin
                            n_status = ST_DUP;
                            n_state  = S_DONE;
                        end
                        ACT_WITHDRAW: begin
                            n_k     = r_pos;
                            n_state = S_REM;
                        end
                        default: begin
                            n_age   = slot_rkey;
                            n_state = S_DONE;
                        end
                    endcase
                end else if ((r_pos + ONE_C) < r_total) begin
                    n_pos   = r_pos + ONE_C;
                    n_state = S_ORD_RD;
                end else if (r_action == ACT_INSERT) begin
                    if (r_total == CAP_C) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end
            end
            // take a freed slot from the order tail, else a never-used one
            S_ALLOC: begin
                if (r_total < r_fill) begin
                    ord_raddr = r_total[SW-1:0];
                    n_state   = S_ALLOC_W;
                end else begin
                    n_slot  = r_fill[SW-1:0];
                    n_fill  = r_fill + ONE_C;
                    n_state = S_SLOT_WR;
                end
            end
            S_ALLOC_W: begin
                n_slot  = ord_rdata;
                n_state = S_SLOT_WR;
            end
            S_SLOT_WR: begin
                slot_we = 1'b1;
                n_pos   = is_pref ? r_pref : r_total;
                n_k     = r_total;
                n_state = ((is_pref ? r_pref : r_total) < r_total) ? S_INS_RD : S_FINAL;
            end
            // open a gap: order[k] = order[k-1]
            S_INS_RD: begin
                ord_raddr = SW'(r_k - ONE_C);
                n_state   = S_INS_WR;
            end
            S_INS_WR: begin
                ord_we    = 1'b1;
                ord_waddr = r_k[SW-1:0];
                ord_wdata = ord_rdata;
                n_k       = r_k - ONE_C;
                n_state   = ((r_k - ONE_C) > r_pos) ? S_INS_RD : S_FINAL;
            end
            // close the gap: order[k] = order[k+1]
            S_REM: begin
                if ((r_k + ONE_C) < r_total) begin
                    ord_raddr = SW'(r_k + ONE_C);
                    n_state   = S_REM_WR;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_REM_WR: begin
                ord_we    = 1'b1;
                ord_waddr = r_k[SW-1:0];
                ord_wdata = ord_rdata;
                n_k       = r_k + ONE_C;
                n_state   = S_REM;
            end
            S_FINAL: begin
                ord_we    = 1'b1;
                ord_wdata = r_slot;
                if (r_action == ACT_INSERT) begin
                    ord_waddr = r_pos[SW-1:0];
                    n_total   = r_total + ONE_C;
                    if (is_pref) begin
                        n_pref = r_pref + ONE_C;
                    end
                end else begin
                    ord_waddr = SW'(r_total - ONE_C);
                    n_total   = r_total - ONE_C;
                    if (r_pos < r_pref) begin
                        n_pref = r_pref - ONE_C;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_served = r_served;
                    n_out_age    = r_age;
                    n_out_count  = r_total;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[hdl/tcpq_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks on the result words of the two-class priority queue.
// ----------------------------------------------------------------------------
module tcpq_checker #(
    parameter int unsigned CAPACITY = tcpq_pkg::DEF_CAPACITY
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic [2:0]                           o_status,
    input wire logic [tcpq_pkg::PORT_ID_W-1:0]       o_served_id,
    input wire logic [tcpq_pkg::KEY_W-1:0]           o_found_age,
    input wire logic [$clog2(CAPACITY+1)-1:0]        o_entry_count
);
    import tcpq_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // a held result stays valid with its entry count unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_entry_count))
        else $error("result word dropped or changed while stalled");

    // count never exceeds capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // full only at capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == CW'(CAPACITY))
        else $error("full reported below capacity");

    // empty only with nothing held
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty reported with entries held");

    // failed operations return no data
    a_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_served_id == '0 && o_found_age == '0)
        else $error("data returned with an error status");

endmodule

bind two_class_priority_queue tcpq_checker #(.CAPACITY(CAPACITY)) u_tcpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_served_id   (o_served_id),
    .o_found_age   (o_found_age),
    .o_entry_count (o_entry_count)
);
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-class priority queue testbench
// Drives insert, serve, withdraw and query words through the input channel,
// predicts each result from a local model of the queue and compares every
// returned word field by field, under several threshold settings and idling.
// ----------------------------------------------------------------------------
module testbench;
    import tcpq_pkg::*;

    localparam int CAP      = 16;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        t_action     action;
        logic [15:0] id;
        logic [7:0]  age;
    } t_op;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] served_id;
        logic [7:0]  found_age;
        logic [4:0]  entry_count;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_action = '0;
    logic [15:0] i_person_id = '0;
    logic [7:0]  i_person_age = '0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready, o_in_ready, o_out_valid;
    logic [2:0]  o_status;
    logic [15:0] o_served_id;
    logic [7:0]  o_found_age;
    logic [4:0]  o_entry_count;

    two_class_priority_queue DUT (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_action, .i_person_id, .i_person_age,
        .o_out_valid, .i_out_ready, .o_status, .o_served_id, .o_found_age,
        .o_entry_count
    );

    always #5 i_clk = ~i_clk;

    // queue model: service order holds (id, key), preferred section first
    logic [15:0] q_id[$];
    logic [7:0]  q_key[$];
    int          n_pref;
    logic [7:0]  threshold = THRESHOLD_RESET;

    t_op  pending_ops[$];
    t_res expected_res[$];
    int   send_idle_pct, recv_idle_pct;
    bit   hold_send;
    int   errors, n_checked, wdog;
    bit   started;
    int   n_ins, n_srv, n_wd, n_qry, n_full, n_dup;

    function automatic int find_entry(logic [15:0] id);
        for (int k = 0; k < q_id.size(); k++)
            if (q_id[k] == id) return k;
        return -1;
    endfunction

    function automatic t_res predict_queue(t_op op);
        t_res r;
        int   p;
        r = '0;
        r.status = ST_OK;
        p = find_entry(op.id);
        case (op.action)
            ACT_INSERT: begin
                if (p >= 0) begin
                    r.status = ST_DUP; n_dup++;
                end else if (q_id.size() >= CAP) begin
                    r.status = ST_FULL; n_full++;
                end else if (op.age >= threshold) begin
                    q_id.insert(n_pref, op.id);
                    q_key.insert(n_pref, op.age);
                    n_pref++;
                end else begin
                    q_id.push_back(op.id);
                    q_key.push_back(op.age);
                end
            end
            ACT_SERVE: begin
                if (q_id.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.served_id = q_id.pop_front();
                    void'(q_key.pop_front());
                    if (n_pref > 0) n_pref--;
                end
            end
            ACT_WITHDRAW: begin
                if (p < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    q_id.delete(p);
                    q_key.delete(p);
                    if (p < n_pref) n_pref--;
                end
            end
            default: begin
                if (p < 0) r.status = ST_NOTFOUND;
                else r.found_age = q_key[p];
            end
        endcase
        r.entry_count = 5'(q_id.size());
        return r;
    endfunction

    // driver: one word at a time from the pending queue
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            expected_res.push_back(predict_queue(t_op'({i_action, i_person_id,
                                                        i_person_age})));
            case (t_action'(i_action))
                ACT_INSERT:   n_ins++;
                ACT_SERVE:    n_srv++;
                ACT_WITHDRAW: n_wd++;
                default:      n_qry++;
            endcase
        end
        if (!i_in_valid || o_in_ready) begin
            if (pending_ops.size() > 0 && !hold_send && i_rst_n &&
                    $urandom_range(99) >= send_idle_pct) begin
                t_op op;
                op = pending_ops.pop_front();
                i_in_valid   <= 1'b1;
                i_action     <= op.action;
                i_person_id  <= op.id;
                i_person_age <= op.age;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (expected_res.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                t_res e;
                e = expected_res.pop_front();
                n_checked++;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_served_id !== e.served_id) begin
                    $error("served_id exp %0d got %0d", e.served_id, o_served_id);
                    errors++;
                end
                if (o_found_age !== e.found_age) begin
                    $error("found_age exp %0d got %0d", e.found_age, o_found_age);
                    errors++;
                end
                if (o_entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d", e.entry_count, o_entry_count);
                    errors++;
                end
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready) || !started)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("testbench failed");
            $finish;
        end
    end

    function automatic t_op mk(t_action a, logic [15:0] id, logic [7:0] age);
        t_op op;
        op.action = a;
        op.id = id;
        op.age = age;
        return op;
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() > 0 || i_in_valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold = v;
        i_cfg_valid <= 1'b0;
    endtask

    // random traffic: ids from a small pool so hits and duplicates are common
    task automatic add_random(int n);
        for (int k = 0; k < n; k++) begin
            logic [15:0] id;
            int          r;
            id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
            if ($urandom_range(4) == 0) id = ~id;
            r = $urandom_range(99);
            if (r < 40)      pending_ops.push_back(mk(ACT_INSERT, id, 8'($urandom)));
            else if (r < 65) pending_ops.push_back(mk(ACT_SERVE, 16'($urandom),
                                                      8'($urandom)));
            else if (r < 82) pending_ops.push_back(mk(ACT_WITHDRAW, id, 8'($urandom)));
            else             pending_ops.push_back(mk(ACT_QUERY, id, 8'($urandom)));
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        started = 1'b1;
        @(posedge i_clk);

        // directed: empty cases, extremes, both classes, duplicate and full
        pending_ops.push_back(mk(ACT_SERVE, 16'hFFFF, 8'hFF));
        pending_ops.push_back(mk(ACT_QUERY, 16'h0000, 8'h00));
        pending_ops.push_back(mk(ACT_WITHDRAW, 16'hFFFF, 8'h00));
        pending_ops.push_back(mk(ACT_INSERT, 16'h0000, 8'h00));
        pending_ops.push_back(mk(ACT_INSERT, 16'hFFFF, 8'hFF));
        pending_ops.push_back(mk(ACT_INSERT, 16'h0000, 8'h3C));
        pending_ops.push_back(mk(ACT_INSERT, 16'h0005, 8'h3C));
        pending_ops.push_back(mk(ACT_INSERT, 16'h0006, 8'h3B));
        pending_ops.push_back(mk(ACT_QUERY, 16'hFFFF, 8'h00));
        pending_ops.push_back(mk(ACT_QUERY, 16'h1234, 8'h00));
        pending_ops.push_back(mk(ACT_WITHDRAW, 16'h0005, 8'h00));
        for (int k = 0; k < 13; k++)
            pending_ops.push_back(mk(ACT_INSERT, 16'(16'h0100 + k), 8'(k * 19)));
        pending_ops.push_back(mk(ACT_INSERT, 16'hAAAA, 8'h55));
        for (int k = 0; k < 4; k++)
            pending_ops.push_back(mk(ACT_SERVE, 16'h0, 8'h0));

        // hold the sender until the queue of results is empty
        hold_send = 1'b1;
        while (expected_res.size() > 0 || i_in_valid) @(posedge i_clk);
        hold_send = 1'b0;

        write_threshold(8'd0);
        send_idle_pct = 34; recv_idle_pct = 88;
        add_random(450);
        write_threshold(8'd255);
        add_random(300);
        write_threshold(8'd128);
        send_idle_pct = 88; recv_idle_pct = 34;
        add_random(550);
        write_threshold(8'd60);
        send_idle_pct = 0; recv_idle_pct = 0;
        add_random(600);
        wait_drained();

        $display("checked %0d results: %0d insert, %0d serve, %0d withdraw, %0d query",
                 n_checked, n_ins, n_srv, n_wd, n_qry);
        $display("duplicate inserts %0d, inserts into a full queue %0d", n_dup, n_full);
        if (errors == 0 && expected_res.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
